// ===== rtl/switch_debounce_press_detector_macros.svh =====
// assertion macros for the switch debounce press detector checker
// expects clk_i and rst_ni to be visible where the macros are used
`ifndef SWITCH_DEBOUNCE_PRESS_DETECTOR_MACROS_SVH
`define SWITCH_DEBOUNCE_PRESS_DETECTOR_MACROS_SVH

// property that must hold in the same cycle once the antecedent is seen
`define SDPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// property that must hold in the cycle after the antecedent
`define SDPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sdpd_pkg.sv =====
// shared types and constants for the switch debounce press detector
// no dependencies
package sdpd_pkg;

  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  localparam logic [15:0] FullScale         = 16'hFFFF;
  localparam logic [31:0] DefaultRepeatDly  = 32'd1000;

  // register index, taken from paddr[4:2]
  typedef enum logic [2:0] {
    REG_ACTIVE_LOW    = 3'd0,
    REG_HOLD_DELAY    = 3'd1,
    REG_REPEAT        = 3'd2,
    REG_FILTER_GAIN   = 3'd3,
    REG_ON_THRESHOLD  = 3'd4,
    REG_OFF_THRESHOLD = 3'd5
  } reg_idx_e;

  typedef enum logic [2:0] {
    EV_NONE         = 3'd0,
    EV_PRESS        = 3'd1,
    EV_RELEASE      = 3'd2,
    EV_LONG_RELEASE = 3'd3,
    EV_LONG_PRESS   = 3'd4
  } event_e;

  typedef struct packed {
    logic        active_low;
    logic [31:0] hold_delay_ms;
    logic [31:0] repeat_ms;
    logic [7:0]  filter_gain;
    logic [15:0] on_threshold;
    logic [15:0] off_threshold;
  } cfg_t;

  typedef struct packed {
    logic        raw_level;
    logic [31:0] time_ms;
  } item_t;

  typedef struct packed {
    event_e ev;
    logic   is_on;
    logic   long_held;
  } res_t;

endpackage

// ===== rtl/switch_debounce_press_detector.sv =====
// top level of the switch debounce press detector: sample and result registers
// depends on sdpd_pkg, sdpd_cfg_regs and sdpd_core
//
//  channel  | handshake             | payload
//  ---------+-----------------------+--------------------------------------
//  in       | in_valid_i/in_ready_o | raw_level_i, time_ms_i
//  out      | out_valid_o/out_ready_i | event_res_o, is_on_o, long_held_o
//  config   | apb psel/penable/pready | paddr, pwdata, prdata
//
// one sample per cycle unless the output stalls; results pass item_q then res_q
// the rate is set by the single multiply-add of the filter update in sdpd_core
// reset clears the debounce state and both pipeline valid flags at once
// a stalled output holds the result register and the sample register behind it,
// while an empty sample register still takes a new transfer
module switch_debounce_press_detector (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       raw_level_i,
  input  logic [31:0]                time_ms_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [2:0]                 event_res_o,
  output logic                       is_on_o,
  output logic                       long_held_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sdpd_pkg::AddrW-1:0] paddr,
  input  logic [sdpd_pkg::DataW-1:0] pwdata,
  output logic [sdpd_pkg::DataW-1:0] prdata,
  output logic                       pready
);

  sdpd_pkg::cfg_t  cfg;
  sdpd_pkg::item_t item_q;
  sdpd_pkg::res_t  res, res_q;
  logic            in_valid_q;
  logic            out_valid_q;
  logic            advance;
  logic            step;

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || advance;
  assign step       = in_valid_q && advance;

  sdpd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sdpd_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (step),
    .item_i (item_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.raw_level <= raw_level_i;
      item_q.time_ms   <= time_ms_i;
    end
    if (step) begin
      res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign event_res_o = res_q.ev;
  assign is_on_o     = res_q.is_on;
  assign long_held_o = res_q.long_held;

endmodule

// ===== rtl/sdpd_cfg_regs.sv =====
// apb configuration registers for the switch debounce press detector
// depends on sdpd_pkg
module sdpd_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sdpd_pkg::AddrW-1:0] paddr,
  input  logic [sdpd_pkg::DataW-1:0] pwdata,
  output logic [sdpd_pkg::DataW-1:0] prdata,
  output logic                       pready,
  output sdpd_pkg::cfg_t             cfg_o
);

  sdpd_pkg::cfg_t     cfg_q;
  sdpd_pkg::reg_idx_e idx;
  logic               wr_en;

  assign pready = 1'b1;
  assign idx    = sdpd_pkg::reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_low    <= 1'b1;
      cfg_q.hold_delay_ms <= 32'd1000;
      cfg_q.repeat_ms     <= 32'd0;
      cfg_q.filter_gain   <= 8'd26;
      cfg_q.on_threshold  <= 16'd58982;
      cfg_q.off_threshold <= 16'd6554;
    end else if (wr_en) begin
      case (idx)
        sdpd_pkg::REG_ACTIVE_LOW:    cfg_q.active_low    <= pwdata[0];
        sdpd_pkg::REG_HOLD_DELAY:    cfg_q.hold_delay_ms <= pwdata;
        sdpd_pkg::REG_REPEAT:        cfg_q.repeat_ms     <= pwdata;
        sdpd_pkg::REG_FILTER_GAIN:   cfg_q.filter_gain   <= pwdata[7:0];
        sdpd_pkg::REG_ON_THRESHOLD:  cfg_q.on_threshold  <= pwdata[15:0];
        sdpd_pkg::REG_OFF_THRESHOLD: cfg_q.off_threshold <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      sdpd_pkg::REG_ACTIVE_LOW:    prdata = {31'd0, cfg_q.active_low};
      sdpd_pkg::REG_HOLD_DELAY:    prdata = cfg_q.hold_delay_ms;
      sdpd_pkg::REG_REPEAT:        prdata = cfg_q.repeat_ms;
      sdpd_pkg::REG_FILTER_GAIN:   prdata = {24'd0, cfg_q.filter_gain};
      sdpd_pkg::REG_ON_THRESHOLD:  prdata = {16'd0, cfg_q.on_threshold};
      sdpd_pkg::REG_OFF_THRESHOLD: prdata = {16'd0, cfg_q.off_threshold};
      default:                     prdata = '0;
    endcase
  end

endmodule

// ===== rtl/sdpd_core.sv =====
// filter, hysteresis and hold timing state for one sample per cycle while step_i is high
// depends on sdpd_pkg
module sdpd_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sdpd_pkg::cfg_t cfg_i,
  input  logic           step_i,
  input  sdpd_pkg::item_t item_i,
  output sdpd_pkg::res_t res_o
);

  logic [15:0] level_q, level_d;
  logic        on_q, on_d;
  logic        long_q, long_d;
  logic        rep_q, rep_d;
  logic [31:0] press_q, press_d;

  logic        sample;
  logic [8:0]  keep_w;
  logic [24:0] keep_prod;
  logic [23:0] drive_term;
  logic [24:0] acc;
  logic [15:0] lvl_new;
  logic [31:0] elapsed;
  logic [31:0] delay;
  sdpd_pkg::event_e ev;

  always_comb begin
    sample     = item_i.raw_level ^ cfg_i.active_low;
    keep_w     = 9'd256 - {1'b0, cfg_i.filter_gain};
    keep_prod  = keep_w * level_q;
    // gain * 65535 written as gain << 16 minus gain
    drive_term = sample ? ({cfg_i.filter_gain, 16'h0000} - {16'h0000, cfg_i.filter_gain})
                        : 24'd0;
    acc        = keep_prod + {1'b0, drive_term} + 25'd128;
    lvl_new    = acc[23:8];
    elapsed    = item_i.time_ms - press_q;
    delay      = (cfg_i.hold_delay_ms == 32'd0) ? sdpd_pkg::DefaultRepeatDly
                                                : cfg_i.hold_delay_ms;

    level_d = lvl_new;
    on_d    = on_q;
    long_d  = long_q;
    rep_d   = rep_q;
    press_d = press_q;
    ev      = sdpd_pkg::EV_NONE;

    if (!on_q && lvl_new >= cfg_i.on_threshold) begin
      ev      = sdpd_pkg::EV_PRESS;
      on_d    = 1'b1;
      level_d = sdpd_pkg::FullScale;
      long_d  = 1'b0;
      rep_d   = 1'b0;
      press_d = item_i.time_ms;
    end else if (on_q && lvl_new <= cfg_i.off_threshold) begin
      ev      = long_q ? sdpd_pkg::EV_LONG_RELEASE : sdpd_pkg::EV_RELEASE;
      on_d    = 1'b0;
      level_d = 16'd0;
      long_d  = 1'b0;
      rep_d   = 1'b0;
    end else if (on_q && cfg_i.repeat_ms != 32'd0) begin
      // first repeat after the hold delay (DefaultRepeatDly when it is zero), then every repeat interval
      if (!rep_q && elapsed >= delay) begin
        ev      = sdpd_pkg::EV_PRESS;
        rep_d   = 1'b1;
        press_d = item_i.time_ms;
      end else if (rep_q && elapsed >= cfg_i.repeat_ms) begin
        ev      = sdpd_pkg::EV_PRESS;
        press_d = item_i.time_ms;
      end
    end else if (on_q && cfg_i.hold_delay_ms != 32'd0 && !long_q) begin
      if (elapsed >= cfg_i.hold_delay_ms) begin
        ev     = sdpd_pkg::EV_LONG_PRESS;
        long_d = 1'b1;
      end
    end

    res_o.ev        = ev;
    res_o.is_on     = on_d;
    res_o.long_held = long_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
      on_q    <= 1'b0;
      long_q  <= 1'b0;
      rep_q   <= 1'b0;
      press_q <= '0;
    end else if (step_i) begin
      level_q <= level_d;
      on_q    <= on_d;
      long_q  <= long_d;
      rep_q   <= rep_d;
      press_q <= press_d;
    end
  end

endmodule

// ===== rtl/sdpd_checker.sv =====
// port-level checks for the switch debounce press detector, bound to the top
// depends on sdpd_pkg and switch_debounce_press_detector_macros.svh
`include "switch_debounce_press_detector_macros.svh"

module sdpd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] event_res_o,
  input logic       is_on_o,
  input logic       long_held_o
);

  `SDPD_ASSERT_NOW(a_press_is_on, out_valid_o && event_res_o == sdpd_pkg::EV_PRESS, is_on_o, "press event with switch off")
  `SDPD_ASSERT_NOW(a_long_press_held, out_valid_o && event_res_o == sdpd_pkg::EV_LONG_PRESS, is_on_o && long_held_o, "long press event without held state")
  `SDPD_ASSERT_NOW(a_release_clears, out_valid_o && (event_res_o == sdpd_pkg::EV_RELEASE || event_res_o == sdpd_pkg::EV_LONG_RELEASE), !is_on_o && !long_held_o, "release event leaves switch held")
  `SDPD_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(event_res_o) && $stable(is_on_o) && $stable(long_held_o), "stalled result changed")

endmodule

bind switch_debounce_press_detector sdpd_checker u_sdpd_checker (.*);

// ===== tb/switch_press_checker.sv =====
// checker for the switch debounce press detector: predicts every result and compares
// depends on sdpd_pkg; watches the sample, result and apb channels of the block
module switch_press_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic                       raw_level_i,
  input  logic [31:0]                time_ms_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic [2:0]                 event_res_i,
  input  logic                       is_on_i,
  input  logic                       long_held_i,
  input  logic                       psel_i,
  input  logic                       penable_i,
  input  logic                       pwrite_i,
  input  logic [sdpd_pkg::AddrW-1:0] paddr_i,
  input  logic [sdpd_pkg::DataW-1:0] pwdata_i,
  input  logic                       pready_i,
  output int                         fail_count_o,
  output int                         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  sdpd_pkg::cfg_t settings;
  logic [15:0]    filt_level;
  logic           sw_on;
  logic           long_seen;
  logic           repeating;
  logic [31:0]    press_ms;
  sdpd_pkg::res_t events_due[$];
  int             mismatches = 0;

  assign fail_count_o = mismatches;

  // one sample through the low-pass filter, the hysteresis and the hold timing
  function automatic sdpd_pkg::res_t debounce_step(input logic raw, input logic [31:0] now);
    logic [15:0]    target;
    logic [31:0]    acc;
    logic [31:0]    elapsed;
    logic [31:0]    first_delay;
    sdpd_pkg::res_t r;
    target = (raw ^ settings.active_low) ? sdpd_pkg::FullScale : 16'h0000;
    acc = 32'(settings.filter_gain) * 32'(target)
        + (32'd256 - 32'(settings.filter_gain)) * 32'(filt_level);
    filt_level = 16'((acc + 32'd128) >> 8);
    elapsed = now - press_ms;
    r.ev = sdpd_pkg::EV_NONE;
    if (!sw_on && filt_level >= settings.on_threshold) begin
      r.ev = sdpd_pkg::EV_PRESS;
      sw_on = 1'b1;
      filt_level = sdpd_pkg::FullScale;
      long_seen = 1'b0;
      repeating = 1'b0;
      press_ms = now;
    end else if (sw_on && filt_level <= settings.off_threshold) begin
      r.ev = long_seen ? sdpd_pkg::EV_LONG_RELEASE : sdpd_pkg::EV_RELEASE;
      sw_on = 1'b0;
      filt_level = 16'h0000;
      long_seen = 1'b0;
      repeating = 1'b0;
    end else if (sw_on && settings.repeat_ms != 32'd0) begin
      first_delay = (settings.hold_delay_ms != 32'd0) ? settings.hold_delay_ms
                                                     : sdpd_pkg::DefaultRepeatDly;
      if (!repeating && elapsed >= first_delay) begin
        r.ev = sdpd_pkg::EV_PRESS;
        repeating = 1'b1;
        press_ms = now;
      end else if (repeating && elapsed >= settings.repeat_ms) begin
        r.ev = sdpd_pkg::EV_PRESS;
        press_ms = now;
      end
    end else if (sw_on && settings.hold_delay_ms != 32'd0 && !long_seen &&
                 elapsed >= settings.hold_delay_ms) begin
      r.ev = sdpd_pkg::EV_LONG_PRESS;
      long_seen = 1'b1;
    end
    r.is_on = sw_on;
    r.long_held = long_seen;
    return r;
  endfunction

  function automatic void compare_field(input string what, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sdpd_pkg::res_t want;
    if (!rst_ni) begin
      settings.active_low    = 1'b1;
      settings.hold_delay_ms = 32'd1000;
      settings.repeat_ms     = 32'd0;
      settings.filter_gain   = 8'd26;
      settings.on_threshold  = 16'd58982;
      settings.off_threshold = 16'd6554;
      filt_level = 16'h0000;
      sw_on      = 1'b0;
      long_seen  = 1'b0;
      repeating  = 1'b0;
      press_ms   = 32'd0;
      events_due.delete();
      pending_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[sdpd_pkg::AddrW-1:2])
          sdpd_pkg::REG_ACTIVE_LOW:    settings.active_low    = pwdata_i[0];
          sdpd_pkg::REG_HOLD_DELAY:    settings.hold_delay_ms = pwdata_i[31:0];
          sdpd_pkg::REG_REPEAT:        settings.repeat_ms     = pwdata_i[31:0];
          sdpd_pkg::REG_FILTER_GAIN:   settings.filter_gain   = pwdata_i[7:0];
          sdpd_pkg::REG_ON_THRESHOLD:  settings.on_threshold  = pwdata_i[15:0];
          sdpd_pkg::REG_OFF_THRESHOLD: settings.off_threshold = pwdata_i[15:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        events_due.push_back(debounce_step(raw_level_i, time_ms_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (events_due.size() == 0) begin
          $display("%0t ns: result with nothing expected, expected none, actual event %0d",
                   $time, event_res_i);
          mismatches++;
        end else begin
          want = events_due.pop_front();
          compare_field("event_res", want.ev, event_res_i);
          compare_field("is_on", want.is_on, is_on_i);
          compare_field("long_held", want.long_held, long_held_i);
        end
      end
      pending_o <= events_due.size();
    end
  end

endmodule

// ===== tb/tb_switch_debounce_press_detector.sv =====
// testbench top for the switch debounce press detector: clock, reset, stimulus, verdict
// depends on sdpd_pkg, switch_debounce_press_detector and switch_press_checker
module tb_switch_debounce_press_detector;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          RandomItems = 1850;
  localparam int          PhaseItems  = 150;
  localparam logic [2:0]  UnmappedIdx = 3'd6;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic                       raw_level_i;
  logic [31:0]                time_ms_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic [2:0]                 event_res_o;
  logic                       is_on_o;
  logic                       long_held_o;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [sdpd_pkg::AddrW-1:0] paddr;
  logic [sdpd_pkg::DataW-1:0] pwdata;
  logic [sdpd_pkg::DataW-1:0] prdata;
  logic                       pready;

  int             checker_fails;
  int             results_pending;
  sdpd_pkg::cfg_t cur_cfg;
  logic [31:0]    now_ms;
  int             items_sent = 0;
  bit             in_steady = 1'b0;
  bit             out_steady = 1'b0;
  int             stall_left = 0;

  switch_debounce_press_detector u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .raw_level_i, .time_ms_i,
    .out_valid_o, .out_ready_i, .event_res_o, .is_on_o, .long_held_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  switch_press_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .raw_level_i  (raw_level_i),
    .time_ms_i    (time_ms_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .event_res_i  (event_res_o),
    .is_on_i      (is_on_o),
    .long_held_i  (long_held_o),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .pready_i     (pready),
    .fail_count_o (checker_fails),
    .pending_o    (results_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #8000000;
    $display("*** FAILED ***");
    $finish;
  end

  // result side: mostly ready, short and long stalls, now and then a stretch with none
  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 199) == 0) out_steady = !out_steady;
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if (!out_steady && $urandom_range(0, 99) < 15) begin
          stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                  : $urandom_range(8, 40);
        end
      end
    end
  end

  function automatic int unsigned idle_cycles();
    int unsigned r;
    if (in_steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic apb_write(input logic [sdpd_pkg::AddrW-1:0] addr,
                           input logic [sdpd_pkg::DataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  task automatic program_regs(input sdpd_pkg::cfg_t c, input bit poke_unmapped);
    apb_write({sdpd_pkg::REG_ACTIVE_LOW, 2'b00}, 32'(c.active_low));
    apb_write({sdpd_pkg::REG_HOLD_DELAY, 2'b00}, c.hold_delay_ms);
    apb_write({sdpd_pkg::REG_REPEAT, 2'b00}, c.repeat_ms);
    apb_write({sdpd_pkg::REG_FILTER_GAIN, 2'b00}, 32'(c.filter_gain));
    apb_write({sdpd_pkg::REG_ON_THRESHOLD, 2'b00}, 32'(c.on_threshold));
    apb_write({sdpd_pkg::REG_OFF_THRESHOLD, 2'b00}, 32'(c.off_threshold));
    // writes past the last register must leave everything alone
    if (poke_unmapped) apb_write({UnmappedIdx, 2'b00}, $urandom);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // valid stays high from one transfer to the next unless a gap is taken
  task automatic send_item(input logic raw, input logic [31:0] t);
    int unsigned gap;
    gap = idle_cycles();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    raw_level_i <= raw;
    time_ms_i   <= t;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (results_pending != 0);
  endtask

  function automatic sdpd_pkg::cfg_t pick_settings(input int phase);
    sdpd_pkg::cfg_t c;
    case (phase)
      0: c = '{1'b0, 32'd0, 32'd0, 8'd255, 16'hFFFF, 16'h0000};
      1: c = '{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd1, 16'h0000, 16'hFFFF};
      2: c = '{1'b0, 32'd1, 32'd1, 8'd128, 16'd40000, 16'd20000};
      3: c = '{1'b1, 32'hFFFF_FFFF, 32'd0, 8'd0, 16'h0000, 16'd1000};
      default: begin
        c.active_low = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 19))
          0, 1, 2: c.hold_delay_ms = 32'd0;
          3, 4:    c.hold_delay_ms = $urandom;
          default: c.hold_delay_ms = $urandom_range(1, 3000);
        endcase
        case ($urandom_range(0, 19))
          0, 1:    c.repeat_ms = $urandom;
          2, 3, 4, 5, 6, 7, 8, 9, 10: c.repeat_ms = 32'd0;
          default: c.repeat_ms = $urandom_range(1, 400);
        endcase
        c.filter_gain = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                    : 8'($urandom_range(16, 255));
        c.on_threshold  = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(32768, 65000));
        c.off_threshold = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(500, 30000));
      end
    endcase
    return c;
  endfunction

  initial begin
    int          phase;
    int          phase_end;
    int          start_count;
    int unsigned step_max;
    int unsigned hold_n;
    int unsigned rel_n;
    logic        lvl;
    in_valid_i  <= 1'b0;
    raw_level_i <= 1'b0;
    time_ms_i   <= 32'd0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    rst_ni      <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: time extremes and a short press too brief to register
    cur_cfg = '{1'b1, 32'd1000, 32'd0, 8'd26, 16'd58982, 16'd6554};
    send_item(1'b1, 32'd0);
    send_item(1'b1, 32'hFFFF_FFFF);
    send_item(1'b0, 32'h8000_0000);
    send_item(1'b0, 32'h7FFF_FFFF);
    send_item(1'b1, 32'd1);

    // fast filter: press, long press across the time wrap, both releases
    drain();
    cur_cfg.filter_gain = 8'd255;
    program_regs(cur_cfg, 1'b1);
    send_item(1'b0, 32'hFFFF_FF00);
    send_item(1'b0, 32'hFFFF_FF00 + 32'd500);
    send_item(1'b0, 32'hFFFF_FF00 + 32'd1000);
    send_item(1'b0, 32'hFFFF_FF00 + 32'd1200);
    send_item(1'b1, 32'hFFFF_FF00 + 32'd1300);
    send_item(1'b0, 32'd5000);
    send_item(1'b1, 32'd5010);

    // auto-repeat with the default first delay
    drain();
    cur_cfg.hold_delay_ms = 32'd0;
    cur_cfg.repeat_ms = 32'd100;
    program_regs(cur_cfg, 1'b0);
    send_item(1'b0, 32'd10000);
    send_item(1'b0, 32'd10999);
    send_item(1'b0, 32'd11000);
    send_item(1'b0, 32'd11099);
    send_item(1'b0, 32'd11100);
    send_item(1'b1, 32'd11150);

    // zero gain freezes the filter
    drain();
    cur_cfg.filter_gain = 8'd0;
    program_regs(cur_cfg, 1'b0);
    send_item(1'b0, 32'd12000);
    send_item(1'b1, 32'd12001);

    now_ms = $urandom;
    phase = 0;
    start_count = items_sent;
    while (items_sent - start_count < RandomItems) begin
      drain();
      cur_cfg = pick_settings(phase);
      program_regs(cur_cfg, phase[0]);
      case ($urandom_range(0, 2))
        0:       step_max = 3;
        1:       step_max = 60;
        default: step_max = 200;
      endcase
      phase_end = items_sent + PhaseItems;
      while (items_sent < phase_end) begin
        in_steady = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 4) == 0) begin
          // noise: random levels and jumps anywhere in time
          repeat ($urandom_range(1, 6)) begin
            now_ms = $urandom;
            send_item(1'($urandom_range(0, 1)), now_ms);
          end
        end else begin
          // a held press with some bounce, then a release with some bounce
          hold_n = $urandom_range(1, 80);
          rel_n  = $urandom_range(1, 40);
          repeat (hold_n) begin
            lvl = ~cur_cfg.active_low;
            if ($urandom_range(0, 9) == 0) lvl = ~lvl;
            now_ms += $urandom_range(0, step_max);
            send_item(lvl, now_ms);
          end
          repeat (rel_n) begin
            lvl = cur_cfg.active_low;
            if ($urandom_range(0, 9) == 0) lvl = ~lvl;
            now_ms += $urandom_range(0, step_max);
            send_item(lvl, now_ms);
          end
        end
      end
      phase++;
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (checker_fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
